/* hw/rtl/pid_value_display_frame_builder_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the P/I/D display frame builder
// Clocked, reset-qualified wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PID_VALUE_DISPLAY_FRAME_BUILDER_ASSERT_SVH
`define PID_VALUE_DISPLAY_FRAME_BUILDER_ASSERT_SVH

// General property, disabled while reset is asserted
`define PVDFB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// A stalled word must hold its value
`define PVDFB_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) \
    ((vld) && !(rdy) |=> $stable(sig))) else $error(msg);

`endif

/* hw/rtl/pvdfb_pkg.sv */
// ----------------------------------------------------------------------------
// pvdfb_pkg
// Shared types, constants and glyph table of the display frame builder.
// ----------------------------------------------------------------------------
package pvdfb_pkg;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned BIN_W   = 14;  // clamped value 0..9999
  localparam int unsigned BCD_W   = 16;  // four decimal digits

  // Binary to BCD conversion: one bit per cycle
  localparam int unsigned CONV_STEPS = BIN_W;
  localparam int unsigned CNT_W      = $clog2(CONV_STEPS);

  // Front/back queue
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Output word sequence
  localparam int unsigned NUM_WORDS = 18;
  localparam int unsigned IDX_W     = $clog2(NUM_WORDS);
  localparam logic [IDX_W-1:0] WORD_MODE = IDX_W'(0);
  localparam logic [IDX_W-1:0] WORD_ADDR = IDX_W'(1);
  localparam logic [IDX_W-1:0] WORD_LAST = IDX_W'(NUM_WORDS - 1);

  // Controller commands and glyphs
  localparam logic [7:0] CMD_MODE_AUTO_INC = 8'h40;
  localparam logic [7:0] CMD_ADDR_START    = 8'hC0;
  localparam logic [7:0] SEG_DOT           = 8'h80;
  localparam logic [7:0] GLYPH_P           = 8'h73;
  localparam logic [7:0] GLYPH_I           = 8'h06;
  localparam logic [7:0] GLYPH_D           = 8'h5E;
  localparam logic [7:0] GLYPH_BLANK       = 8'h00;

  // Letters
  localparam logic [7:0] LETTER_P = 8'h50;
  localparam logic [7:0] LETTER_I = 8'h49;
  localparam logic [7:0] LETTER_D = 8'h44;

  localparam logic [BIN_W-1:0] VALUE_MAX = BIN_W'(9999);
  localparam logic [7:0]       STEP_LIMIT = 8'd3;

  typedef enum logic [1:0] {
    FRONT_IDLE,
    FRONT_CONV,
    FRONT_PUSH
  } front_state_e;

  // One classified screen, handed from front to back
  typedef struct packed {
    logic [7:0]       seg0;    // parameter glyph
    logic [7:0]       led;     // LED 0..7 flags
    logic [BCD_W-1:0] digits;  // units, tenths, hundredths, thousandths
  } pvdfb_entry_t;

  // Decimal digit to segment code
  function automatic logic [7:0] digit_glyph(input logic [3:0] d);
    logic [7:0] g;
    unique case (d)
      4'd0:    g = 8'h3F;
      4'd1:    g = 8'h06;
      4'd2:    g = 8'h5B;
      4'd3:    g = 8'h4F;
      4'd4:    g = 8'h66;
      4'd5:    g = 8'h6D;
      4'd6:    g = 8'h7D;
      4'd7:    g = 8'h07;
      4'd8:    g = 8'h7F;
      4'd9:    g = 8'h6F;
      default: g = GLYPH_BLANK;
    endcase
    return g;
  endfunction

endpackage

/* hw/rtl/pvdfb_if.sv */
// ----------------------------------------------------------------------------
// pvdfb_if
// Valid/ready channels: screen input and controller byte output.
// ----------------------------------------------------------------------------
interface pvdfb_in_if import pvdfb_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [BYTE_W-1:0]         letter_code;
  logic signed [VALUE_W-1:0] value_milli;
  logic [BYTE_W-1:0]         step_index;
  logic                      dirty;

  modport source (output valid, letter_code, value_milli, step_index, dirty,
                  input ready);
  modport sink (input valid, letter_code, value_milli, step_index, dirty,
                output ready);
  modport monitor (input valid, ready, letter_code, value_milli, step_index, dirty);
endinterface

interface pvdfb_out_if import pvdfb_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              frame_start;
  logic              last;

  modport source (output valid, data_byte, frame_start, last, input ready);
  modport sink (input valid, data_byte, frame_start, last, output ready);
  modport monitor (input valid, ready, data_byte, frame_start, last);
endinterface

/* hw/rtl/pvdfb_front.sv */
// ----------------------------------------------------------------------------
// pvdfb_front
// Accepts a screen word, clamps the value, flags LEDs and converts the
// value to four BCD digits with a bit-serial shift-and-add-3 unit.
// ----------------------------------------------------------------------------
module pvdfb_front import pvdfb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  pvdfb_in_if.sink     in_i,
  output logic         push_valid_o,
  input  logic         push_ready_i,
  output pvdfb_entry_t push_data_o
);

  front_state_e     state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [BIN_W-1:0] bin_q, bin_d;
  logic [BCD_W-1:0] bcd_q, bcd_d;
  logic [7:0]       seg0_q, seg0_d;
  logic [7:0]       led_q, led_d;
  logic [BCD_W-1:0] bcd_adj;
  logic [BIN_W-1:0] clamped;
  logic [7:0]       glyph;
  logic [7:0]       led_new;

  // Clamp to 0..9999
  always_comb begin
    if (in_i.value_milli[VALUE_W-1]) begin
      clamped = '0;
    end else if (in_i.value_milli[VALUE_W-2:0] > (VALUE_W-1)'(VALUE_MAX)) begin
      clamped = VALUE_MAX;
    end else begin
      clamped = in_i.value_milli[BIN_W-1:0];
    end
  end

  // Letter glyph and LED flags
  always_comb begin
    glyph   = GLYPH_BLANK;
    led_new = '0;
    priority if (in_i.letter_code == LETTER_P) begin
      glyph      = GLYPH_P;
      led_new[0] = 1'b1;
    end else if (in_i.letter_code == LETTER_I) begin
      glyph      = GLYPH_I;
      led_new[1] = 1'b1;
    end else if (in_i.letter_code == LETTER_D) begin
      glyph      = GLYPH_D;
      led_new[2] = 1'b1;
    end else begin
      glyph = GLYPH_BLANK;
    end
    if (in_i.step_index < STEP_LIMIT) begin
      led_new[3'd4 + in_i.step_index[1:0]] = 1'b1;
    end
    led_new[7] = in_i.dirty;
  end

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int n = 0; n < BCD_W / 4; n++) begin
      bcd_adj[n*4 +: 4] = (bcd_q[n*4 +: 4] >= 4'd5) ? bcd_q[n*4 +: 4] + 4'd3
                                                    : bcd_q[n*4 +: 4];
    end
  end

  // Next state and outputs
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    bin_d        = bin_q;
    bcd_d        = bcd_q;
    seg0_d       = seg0_q;
    led_d        = led_q;
    in_i.ready   = 1'b0;
    push_valid_o = 1'b0;
    unique case (state_q)
      FRONT_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          bin_d   = clamped;
          bcd_d   = '0;
          cnt_d   = '0;
          seg0_d  = glyph;
          led_d   = led_new;
          state_d = FRONT_CONV;
        end
      end
      FRONT_CONV: begin
        bcd_d = {bcd_adj[BCD_W-2:0], bin_q[BIN_W-1]};
        bin_d = {bin_q[BIN_W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(CONV_STEPS - 1)) begin
          state_d = FRONT_PUSH;
        end
      end
      FRONT_PUSH: begin
        push_valid_o = 1'b1;
        if (push_ready_i) begin
          state_d = FRONT_IDLE;
        end
      end
      default: state_d = FRONT_IDLE;
    endcase
  end

  assign push_data_o = '{seg0: seg0_q, led: led_q, digits: bcd_q};

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FRONT_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    seg0_q <= seg0_d;
    led_q  <= led_d;
  end

endmodule

/* hw/rtl/pvdfb_queue.sv */
// ----------------------------------------------------------------------------
// pvdfb_queue
// Short FIFO of classified screens between front and back.
// ----------------------------------------------------------------------------
module pvdfb_queue import pvdfb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  pvdfb_entry_t push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output pvdfb_entry_t pop_data_o
);

  pvdfb_entry_t      mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* hw/rtl/pvdfb_back.sv */
// ----------------------------------------------------------------------------
// pvdfb_back
// Walks the 18-word controller sequence for one screen into an output
// register, one word per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module pvdfb_back import pvdfb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         pop_valid_i,
  output logic         pop_ready_o,
  input  pvdfb_entry_t pop_data_i,
  pvdfb_out_if.source  out_o
);

  pvdfb_entry_t     cur_q;
  logic             busy_q;
  logic [IDX_W-1:0] idx_q;
  logic             valid_q;
  logic [7:0]       byte_q, byte_d;
  logic             start_q, start_d;
  logic             last_q;
  logic             load, emit, at_last;
  logic [IDX_W-1:0] slot;
  logic [2:0]       pos;

  assign load        = !valid_q || out_o.ready;
  assign emit        = busy_q && load;
  assign at_last     = (idx_q == WORD_LAST);
  assign pop_ready_o = !busy_q || (emit && at_last);

  // Word for the current index
  assign slot = idx_q - IDX_W'(2);
  assign pos  = slot[3:1];

  always_comb begin
    start_d = 1'b0;
    byte_d  = GLYPH_BLANK;
    priority if (idx_q == WORD_MODE) begin
      byte_d  = CMD_MODE_AUTO_INC;
      start_d = 1'b1;
    end else if (idx_q == WORD_ADDR) begin
      byte_d  = CMD_ADDR_START;
      start_d = 1'b1;
    end else if (slot[0]) begin
      byte_d = {7'b0, cur_q.led[pos]};
    end else begin
      unique case (pos)
        3'd0:    byte_d = cur_q.seg0;
        3'd2:    byte_d = digit_glyph(cur_q.digits[15:12]) | SEG_DOT;
        3'd3:    byte_d = digit_glyph(cur_q.digits[11:8]);
        3'd4:    byte_d = digit_glyph(cur_q.digits[7:4]);
        3'd5:    byte_d = digit_glyph(cur_q.digits[3:0]);
        default: byte_d = GLYPH_BLANK;
      endcase
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.data_byte   = byte_q;
  assign out_o.frame_start = start_q;
  assign out_o.last        = last_q;

  // Sequencer and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= busy_q;
      end
      if (pop_valid_i && pop_ready_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (emit) begin
        busy_q <= !at_last;
        idx_q  <= idx_q + 1'b1;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (pop_valid_i && pop_ready_o) begin
      cur_q <= pop_data_i;
    end
    if (emit) begin
      byte_q  <= byte_d;
      start_q <= start_d;
      last_q  <= at_last;
    end
  end

endmodule

/* hw/rtl/pid_value_display_frame_builder.sv */
// ----------------------------------------------------------------------------
// pid_value_display_frame_builder
// Builds the seven-segment controller byte stream for one P/I/D screen.
// ----------------------------------------------------------------------------
// Each accepted screen word yields 18 output words: the auto-increment mode
// command 0x40 (frame start), the start address 0xC0 (frame start), then 16
// words alternating segment code and LED byte for digit positions 0..7; the
// last carries last=1. The output runs at one word per cycle while out_o.ready
// is not held low. The front end works through each screen in order (accept,
// 14 bit-serial BCD steps, hand-off) and a two-entry queue lets it work on the
// next screen while the back end is still emitting.
module pid_value_display_frame_builder import pvdfb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  pvdfb_in_if.sink    in_i,
  pvdfb_out_if.source out_o
);

  pvdfb_entry_t push_data, pop_data;
  logic         push_valid, push_ready;
  logic         pop_valid, pop_ready;

  pvdfb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  pvdfb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  pvdfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_o       (out_o)
  );

endmodule

/* hw/rtl/pvdfb_checker.sv */
// ----------------------------------------------------------------------------
// pvdfb_checker
// Port-level checks of the output word stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "pid_value_display_frame_builder_assert.svh"

module pvdfb_checker import pvdfb_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  pvdfb_in_if.sink    in_i,
  pvdfb_out_if.source out_i
);

  logic in_seen;
  logic out_fire;

  assign in_seen  = in_i.valid && in_i.ready;
  assign out_fire = out_i.valid && out_i.ready;

  // Stalled word holds
  `PVDFB_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_i.valid, out_i.ready,
    {out_i.data_byte, out_i.frame_start, out_i.last}, "stalled output word changed")

  // Only the two command words open a frame
  `PVDFB_ASSERT(a_start_is_cmd, clk_i, rst_ni,
    out_i.valid && out_i.frame_start |->
    (out_i.data_byte == CMD_MODE_AUTO_INC || out_i.data_byte == CMD_ADDR_START),
    "frame start on a non-command word")

  // Closing word is an LED byte
  `PVDFB_ASSERT(a_last_is_led, clk_i, rst_ni,
    out_i.valid && out_i.last |-> !out_i.frame_start && out_i.data_byte[7:1] == 7'b0,
    "last word is not an LED byte")

  // Mode command is followed at once by the address command
  `PVDFB_ASSERT(a_mode_then_addr, clk_i, rst_ni,
    out_fire && out_i.frame_start && out_i.data_byte == CMD_MODE_AUTO_INC |=>
    out_i.valid && out_i.frame_start && out_i.data_byte == CMD_ADDR_START && !in_seen
    || out_i.valid && out_i.frame_start && out_i.data_byte == CMD_ADDR_START,
    "address command does not follow mode command")

endmodule

bind pid_value_display_frame_builder pvdfb_checker u_pvdfb_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_i  (out_o)
);

/* verif/pid_value_display_frame_builder_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_value_display_frame_builder_test
// Self-checking bench for the P/I/D display frame builder. Screen words are
// driven from a queue. Every accepted screen is expanded here into its 18
// controller bytes. Each output word is checked against the oldest expected
// byte. Both sides idle at random, and there is one long output hold-off.
// ----------------------------------------------------------------------------
module pid_value_display_frame_builder_test;
  import pvdfb_pkg::*;

  localparam int unsigned RANDOM_SCREENS = 350;
  localparam int unsigned STALL_LIMIT    = 2000;  // cycles with no word moving
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned HOLD_CYCLES    = 200;
  localparam int unsigned PHASE1_START   = 130;   // accepted screens
  localparam int unsigned PHASE2_START   = 250;

  // Segment codes for decimal digits 0..9
  localparam logic [7:0] SEVEN_SEG_DIGITS [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  typedef struct {
    logic [7:0]         letter;
    logic signed [15:0] value;
    logic [7:0]         step;
    logic               dirty;
  } screen_t;

  typedef struct {
    logic [7:0] data;
    logic       start;
    logic       last;
  } ctrl_byte_t;

  logic clk;
  logic rst_n;

  pvdfb_in_if  in_if ();
  pvdfb_out_if out_if ();

  pid_value_display_frame_builder u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  screen_t     screens_pending[$];
  ctrl_byte_t  bytes_expected[$];
  int unsigned screens_accepted = 0;
  int unsigned idle_cycles      = 0;
  int unsigned errors           = 0;
  logic        in_fired         = 1'b0;
  int unsigned hold_left        = 0;
  bit          hold_done        = 1'b0;

  // Clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Known values on every input from time zero
  initial begin
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.letter_code  = '0;
    in_if.value_milli  = '0;
    in_if.step_index   = '0;
    in_if.dirty        = 1'b0;
    out_if.ready       = 1'b0;
  end

  // Idle percentage per side, by test phase
  function automatic int unsigned send_idle_pct();
    if (screens_accepted < PHASE1_START) return 13;
    if (screens_accepted < PHASE2_START) return 65;
    return 0;
  endfunction

  function automatic int unsigned recv_idle_pct();
    if (screens_accepted < PHASE1_START) return 65;
    if (screens_accepted < PHASE2_START) return 13;
    return 0;
  endfunction

  function automatic screen_t make_screen(logic [7:0] letter, int value, logic [7:0] step,
                                          logic dirty);
    screen_t s;
    s.letter = letter;
    s.value  = 16'(value);
    s.step   = step;
    s.dirty  = dirty;
    return s;
  endfunction

  // Mostly valid letters and in-range values, with full-range noise
  function automatic screen_t random_screen();
    screen_t     s;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25)      s.letter = LETTER_P;
    else if (r < 50) s.letter = LETTER_I;
    else if (r < 75) s.letter = LETTER_D;
    else             s.letter = 8'($urandom_range(255));
    r = $urandom_range(99);
    if (r < 55)      s.value = 16'($urandom_range(9999));
    else if (r < 62) s.value = 16'($urandom_range(10));
    else if (r < 70) s.value = 16'($urandom_range(10010, 9990));
    else if (r < 85) s.value = 16'($urandom);
    else if (r < 93) s.value = 16'($urandom_range(32767, 10000));
    else             s.value = 16'(-$urandom_range(32768, 1));
    if ($urandom_range(99) < 80) s.step = 8'($urandom_range(3));
    else                         s.step = 8'($urandom_range(255));
    s.dirty = 1'($urandom_range(1));
    return s;
  endfunction

  // Expand one screen into its controller byte sequence
  task automatic predict_frame(input screen_t s);
    logic [7:0] seg [8];
    logic [7:0] lit;
    ctrl_byte_t b;
    int         v;
    for (int i = 0; i < 8; i++) seg[i] = GLYPH_BLANK;
    lit = '0;
    // clamp: negatives to zero, large values to 9.999
    v = s.value[15] ? 0 : int'(s.value);
    if (v > 9999) v = 9999;
    case (s.letter)
      LETTER_P: begin
        seg[0] = GLYPH_P;
        lit[0] = 1'b1;
      end
      LETTER_I: begin
        seg[0] = GLYPH_I;
        lit[1] = 1'b1;
      end
      LETTER_D: begin
        seg[0] = GLYPH_D;
        lit[2] = 1'b1;
      end
      default: ;
    endcase
    seg[2] = SEVEN_SEG_DIGITS[(v / 1000) % 10] | SEG_DOT;
    seg[3] = SEVEN_SEG_DIGITS[(v / 100) % 10];
    seg[4] = SEVEN_SEG_DIGITS[(v / 10) % 10];
    seg[5] = SEVEN_SEG_DIGITS[v % 10];
    if (s.step < STEP_LIMIT) lit[4 + s.step] = 1'b1;
    if (s.dirty) lit[7] = 1'b1;
    b = '{data: CMD_MODE_AUTO_INC, start: 1'b1, last: 1'b0};
    bytes_expected.push_back(b);
    b = '{data: CMD_ADDR_START, start: 1'b1, last: 1'b0};
    bytes_expected.push_back(b);
    for (int i = 0; i < 8; i++) begin
      b = '{data: seg[i], start: 1'b0, last: 1'b0};
      bytes_expected.push_back(b);
      b = '{data: {7'b0, lit[i]}, start: 1'b0, last: (i == 7)};
      bytes_expected.push_back(b);
    end
  endtask

  // Screen driver: holds a word until taken, idles between words
  always @(negedge clk) begin : drive_screens
    screen_t s;
    if (rst_n && !(in_if.valid && !in_fired)) begin
      if (screens_pending.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
        s = screens_pending.pop_front();
        in_if.valid       <= 1'b1;
        in_if.letter_code <= s.letter;
        in_if.value_milli <= s.value;
        in_if.step_index  <= s.step;
        in_if.dirty       <= s.dirty;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Byte receiver: random stalls plus one long hold-off in the last phase
  always @(negedge clk) begin : drive_ready
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_if.ready <= 1'b0;
      end else if (screens_accepted >= PHASE2_START && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct());
      end
    end
  end

  // Monitor: predict on screen accept, check each output word
  always @(posedge clk) begin : watch_ports
    ctrl_byte_t want;
    bit         moved;
    moved = 1'b0;
    in_fired <= rst_n && in_if.valid && in_if.ready;
    if (rst_n && in_if.valid && in_if.ready) begin
      predict_frame('{letter: in_if.letter_code, value: in_if.value_milli,
                      step: in_if.step_index, dirty: in_if.dirty});
      screens_accepted++;
      moved = 1'b1;
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      moved = 1'b1;
      if (bytes_expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected word data_byte=%02h frame_start=%0b last=%0b",
                 $time, out_if.data_byte, out_if.frame_start, out_if.last);
      end else begin
        want = bytes_expected.pop_front();
        if (out_if.data_byte !== want.data) begin
          errors++;
          $display("%0t: data_byte expected %02h actual %02h",
                   $time, want.data, out_if.data_byte);
        end
        if (out_if.frame_start !== want.start) begin
          errors++;
          $display("%0t: frame_start expected %0b actual %0b",
                   $time, want.start, out_if.frame_start);
        end
        if (out_if.last !== want.last) begin
          errors++;
          $display("%0t: last expected %0b actual %0b", $time, want.last, out_if.last);
        end
      end
    end
    if (!rst_n || moved) idle_cycles <= 0;
    else                 idle_cycles <= idle_cycles + 1;
  end

  // Stimulus, reset and end of run
  initial begin : run_test
    // directed: clamp edges, every letter, step edges, dirty both ways
    screens_pending.push_back(make_screen(LETTER_P, 0, 8'd0, 1'b0));
    screens_pending.push_back(make_screen(LETTER_I, 9999, 8'd1, 1'b1));
    screens_pending.push_back(make_screen(LETTER_D, 10000, 8'd2, 1'b0));
    screens_pending.push_back(make_screen(LETTER_P, 32767, 8'd3, 1'b1));
    screens_pending.push_back(make_screen(LETTER_I, -1, 8'd255, 1'b0));
    screens_pending.push_back(make_screen(LETTER_D, -32768, 8'd0, 1'b1));
    screens_pending.push_back(make_screen(8'h00, 1, 8'd1, 1'b0));
    screens_pending.push_back(make_screen(8'hFF, 1234, 8'd2, 1'b1));
    screens_pending.push_back(make_screen(8'h70, 5678, 8'd4, 1'b0));
    screens_pending.push_back(make_screen(8'h51, 9000, 8'd128, 1'b1));
    screens_pending.push_back(make_screen(LETTER_P, 999, 8'd2, 1'b1));
    screens_pending.push_back(make_screen(LETTER_I, 10, 8'd0, 1'b0));
    screens_pending.push_back(make_screen(LETTER_D, 100, 8'd1, 1'b1));
    screens_pending.push_back(make_screen(8'h4F, 2468, 8'd127, 1'b0));
    screens_pending.push_back(make_screen(LETTER_P, 13579, 8'd2, 1'b0));
    screens_pending.push_back(make_screen(8'hAA, -21846, 8'hAA, 1'b1));
    screens_pending.push_back(make_screen(8'h55, 21845, 8'h55, 1'b0));
    for (int i = 0; i < RANDOM_SCREENS; i++) screens_pending.push_back(random_screen());

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // wait for every screen and every byte, bounded by the watchdog
    while ((screens_pending.size() > 0 || in_if.valid || bytes_expected.size() > 0)
           && idle_cycles < STALL_LIMIT)
      @(negedge clk);

    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("Verification failed");
    end else begin
      // catch stray words after the last expected byte
      repeat (DRAIN_CYCLES) @(negedge clk);
      if (errors == 0 && bytes_expected.size() == 0) begin
        $display("Verification passed");
      end else begin
        $display("Verification failed");
      end
    end
    $finish;
  end

endmodule
